/* rtl/streaming_merge_priority_queue_macros.svh */
// assertion macros for the streaming merge priority queue
// used by the top level only, no other dependencies
`ifndef STREAMING_MERGE_PRIORITY_QUEUE_MACROS_SVH
`define STREAMING_MERGE_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SMPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SMPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/smpq_pkg.sv */
// shared constants and types for the streaming merge priority queue
// no dependencies
`timescale 1ns / 1ps

package smpq_pkg;

    localparam int SID_BITS     = 4;
    localparam int OUT_SID_BITS = 5;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // per-cycle operation broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_op;

endpackage

/* rtl/smpq_cell.sv */
// one cell of the sorted chain: holds one (value, stream id) entry
// depends on smpq_pkg
`timescale 1ns / 1ps

module smpq_cell #(
    parameter int VALUE_BITS = 32
) (
    input  logic                              i_clk,
    input  smpq_pkg::t_op                     i_op,
    input  logic                              i_occ,
    input  logic signed [VALUE_BITS-1:0]      i_new_value,
    input  logic [smpq_pkg::SID_BITS-1:0]     i_new_sid,
    input  logic                              i_left_lt,
    input  logic signed [VALUE_BITS-1:0]      i_left_value,
    input  logic [smpq_pkg::SID_BITS-1:0]     i_left_sid,
    input  logic signed [VALUE_BITS-1:0]      i_right_value,
    input  logic [smpq_pkg::SID_BITS-1:0]     i_right_sid,
    output logic                              o_lt,
    output logic signed [VALUE_BITS-1:0]      o_value,
    output logic [smpq_pkg::SID_BITS-1:0]     o_sid
);

    logic signed [VALUE_BITS-1:0]  r_value;
    logic signed [VALUE_BITS-1:0]  n_value;
    logic [smpq_pkg::SID_BITS-1:0] r_sid;
    logic [smpq_pkg::SID_BITS-1:0] n_sid;

    // new entry sorts before the held one, or this cell is empty
    assign o_lt = !i_occ
               || (i_new_value < r_value)
               || ((i_new_value == r_value) && (i_new_sid < r_sid));

    always_comb begin
        n_value = r_value;
        n_sid   = r_sid;
        if (i_op.push && o_lt) begin
            if (i_left_lt) begin
                n_value = i_left_value;
                n_sid   = i_left_sid;
            end else begin
                n_value = i_new_value;
                n_sid   = i_new_sid;
            end
        end else if (i_op.pop) begin
            n_value = i_right_value;
            n_sid   = i_right_sid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_sid   <= n_sid;
    end

    assign o_value = r_value;
    assign o_sid   = r_sid;

endmodule

/* rtl/streaming_merge_priority_queue.sv */
// Merge priority queue for external sort: a chain of MAX_STREAMS cells kept
// sorted by (signed value, stream id), smallest in the first cell. A push
// inserts in place and a pop shifts the chain by one, both in the cycle the
// item is accepted, so the block takes one item per clock while o_stall is
// low, and the result is registered in the output. The cycle is set by the
// value compare that every cell makes against the incoming item. A pop of
// an empty queue returns all ones with o_was_empty; a push into a full queue
// is dropped with o_overflow. No clearing pass is needed after reset.
// depends on smpq_pkg, smpq_cell and streaming_merge_priority_queue_macros.svh
`timescale 1ns / 1ps

`include "streaming_merge_priority_queue_macros.svh"

module streaming_merge_priority_queue #(
    parameter int MAX_STREAMS = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_func,
    input  logic [smpq_pkg::SID_BITS-1:0]          i_stream_id,
    input  logic signed [VALUE_BITS-1:0]           i_value,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [VALUE_BITS-1:0]           o_out_value,
    output logic signed [smpq_pkg::OUT_SID_BITS-1:0] o_out_stream,
    output logic                                   o_was_empty,
    output logic                                   o_has_more,
    output logic                                   o_overflow
);

    localparam int CNT_W = $clog2(MAX_STREAMS + 1);

    logic                 w_in_acc;
    logic                 w_full;
    logic                 w_empty;
    smpq_pkg::t_op        w_op;

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    logic                 r_out_valid;
    logic                 n_out_valid;
    logic signed [VALUE_BITS-1:0]             r_out_value;
    logic signed [VALUE_BITS-1:0]             n_out_value;
    logic signed [smpq_pkg::OUT_SID_BITS-1:0] r_out_stream;
    logic signed [smpq_pkg::OUT_SID_BITS-1:0] n_out_stream;
    logic                 r_was_empty;
    logic                 n_was_empty;
    logic                 r_has_more;
    logic                 n_has_more;
    logic                 r_overflow;
    logic                 n_overflow;

    logic signed [VALUE_BITS-1:0]      w_value [MAX_STREAMS];
    logic [smpq_pkg::SID_BITS-1:0]     w_sid   [MAX_STREAMS];
    logic                              w_lt    [MAX_STREAMS];

    assign o_stall  = r_out_valid && i_stall;
    assign w_in_acc = i_valid && !o_stall;
    assign w_full   = (r_count == CNT_W'(MAX_STREAMS));
    assign w_empty  = (r_count == '0);

    assign w_op.push = w_in_acc && (i_func == smpq_pkg::FUNC_PUSH) && !w_full;
    assign w_op.pop  = w_in_acc && (i_func == smpq_pkg::FUNC_POP) && !w_empty;

    // sorted chain
    for (genvar g = 0; g < MAX_STREAMS; g++) begin : g_cell
        logic                           w_left_lt;
        logic signed [VALUE_BITS-1:0]   w_left_value;
        logic [smpq_pkg::SID_BITS-1:0]  w_left_sid;
        logic signed [VALUE_BITS-1:0]   w_right_value;
        logic [smpq_pkg::SID_BITS-1:0]  w_right_sid;

        if (g == 0) begin : g_first
            assign w_left_lt    = 1'b0;
            assign w_left_value = '0;
            assign w_left_sid   = '0;
        end else begin : g_mid
            assign w_left_lt    = w_lt[g-1];
            assign w_left_value = w_value[g-1];
            assign w_left_sid   = w_sid[g-1];
        end

        if (g == MAX_STREAMS - 1) begin : g_last
            assign w_right_value = w_value[g];
            assign w_right_sid   = w_sid[g];
        end else begin : g_inner
            assign w_right_value = w_value[g+1];
            assign w_right_sid   = w_sid[g+1];
        end

        smpq_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_op          (w_op),
            .i_occ         (CNT_W'(g) < r_count),
            .i_new_value   (i_value),
            .i_new_sid     (i_stream_id),
            .i_left_lt     (w_left_lt),
            .i_left_value  (w_left_value),
            .i_left_sid    (w_left_sid),
            .i_right_value (w_right_value),
            .i_right_sid   (w_right_sid),
            .o_lt          (w_lt[g]),
            .o_value       (w_value[g]),
            .o_sid         (w_sid[g])
        );
    end

    always_comb begin
        n_count      = r_count;
        n_out_valid  = r_out_valid && i_stall;
        n_out_value  = r_out_value;
        n_out_stream = r_out_stream;
        n_was_empty  = r_was_empty;
        n_has_more   = r_has_more;
        n_overflow   = r_overflow;
        if (w_op.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_op.pop) begin
            n_count = r_count - CNT_W'(1);
        end
        if (w_in_acc) begin
            n_out_valid  = 1'b1;
            n_out_value  = '1;
            n_out_stream = '1;
            n_was_empty  = (i_func == smpq_pkg::FUNC_POP) && w_empty;
            n_overflow   = (i_func == smpq_pkg::FUNC_PUSH) && w_full;
            n_has_more   = (n_count != '0);
            if (w_op.pop) begin
                n_out_value  = w_value[0];
                n_out_stream = {1'b0, w_sid[0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out_value  <= n_out_value;
        r_out_stream <= n_out_stream;
        r_was_empty  <= n_was_empty;
        r_has_more   <= n_has_more;
        r_overflow   <= n_overflow;
    end

    assign o_valid      = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_stream = r_out_stream;
    assign o_was_empty  = r_was_empty;
    assign o_has_more   = r_has_more;
    assign o_overflow   = r_overflow;

    `SMPQ_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_STREAMS), "entry count above depth")
    `SMPQ_ASSERT_IMP(a_head_sorted, i_clk, i_rst_n, r_count >= CNT_W'(2), !((w_value[1] < w_value[0]) || ((w_value[1] == w_value[0]) && (w_sid[1] < w_sid[0]))), "first two cells out of order")
    `SMPQ_ASSERT_NXT(a_push_count, i_clk, i_rst_n, w_op.push, r_count == CNT_W'($past(r_count) + CNT_W'(1)), "push did not grow the queue")
    `SMPQ_ASSERT_NXT(a_empty_pop, i_clk, i_rst_n, w_in_acc && (i_func == smpq_pkg::FUNC_POP) && w_empty, o_valid && o_was_empty && !o_has_more, "empty pop not flagged")
    `SMPQ_ASSERT_IMP(a_overflow_full, i_clk, i_rst_n, o_valid && o_overflow, o_has_more && !o_was_empty && w_full, "overflow without full queue")

endmodule
